/* sv/pfa_pkg.sv */
// Shared widths for the polygon fan area block.
package pfa_pkg;

  // Signed operand width of the shared multiplier: a sign-extended coordinate
  // difference, or a zero-extended 32-bit half of a cross term.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  // Sum of three squared cross terms, with two guard bits above 2^128.
  localparam int ACC_W  = 130;
  localparam int ROOT_W = 64;
  localparam int SUM_W  = 64;
  localparam int AREA_W = 63;

endpackage

/* sv/pfa_mul.sv */
// Shared signed multiplier with a registered product.
module pfa_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pfa_pkg::MUL_W-1:0]   a,
  input  logic signed [pfa_pkg::MUL_W-1:0]   b,
  output logic signed [pfa_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

/* sv/pfa_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
module pfa_isqrt #(
  parameter int STEPS = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*STEPS-1:0]            radicand,
  output logic                          done,
  output logic [pfa_pkg::ROOT_W-1:0]    root
);

  localparam int CNT_W = $clog2(STEPS);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [2*STEPS-1:0] rad;
  logic [STEPS:0]     rem;
  logic [STEPS-1:0]   q;

  logic [STEPS+2:0]   rem2;
  logic [STEPS+2:0]   trial;
  logic [STEPS+2:0]   rem_sub;
  logic               ge;

  // Bring down the next two radicand bits and try appending a one.
  assign rem2    = {rem, rad[2*STEPS-1 -: 2]};
  assign trial   = (STEPS+3)'({q, 2'b01});
  assign ge      = rem2 >= trial;
  assign rem_sub = rem2 - trial;
  assign root    = pfa_pkg::ROOT_W'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        rem <= ge ? rem_sub[STEPS:0] : rem2[STEPS:0];
        rad <= rad << 2;
        q   <= {q[STEPS-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* sv/polygon_fan_area.sv */
// Polygon fan area: top level with the cross product and sum sequencer.
//
// Vertices enter one item at a time on the in channel (in_valid/in_ready),
// signed coordinates with 8 fraction bits and last_vertex on the final one.
// One item leaves on the out channel (out_valid/out_ready) per polygon, on
// its last vertex: area with 16 fraction bits and the saturated flag.
// Fewer than three vertices give an area of zero.
// The first two vertices of a polygon go from S_IDLE straight to S_FINISH.
// Every later vertex runs the cross product and squaring on the one shared
// multiplier in S_CROSS, then the iterative square root in S_SQRT over
// STEPS = min(64, 2*COORD_BITS + 2) root bits. in_ready is high only
// between vertices.
// A result sits in an output register until taken; the next vertex is
// accepted meanwhile, and a later last vertex waits at its final cycle
// while the receiver stalls.
// Synchronous reset rst clears the polygon state and drops any pending
// result.
module polygon_fan_area #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  coord_x,
  input  logic signed [COORD_BITS-1:0]  coord_y,
  input  logic signed [COORD_BITS-1:0]  coord_z,
  input  logic                          last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::AREA_W-1:0]    area,
  output logic                          saturated
);

  localparam int MW     = pfa_pkg::MUL_W;
  localparam int PW     = pfa_pkg::PROD_W;
  localparam int ACC_W  = pfa_pkg::ACC_W;
  localparam int SUM_W  = pfa_pkg::SUM_W;
  localparam int CB     = COORD_BITS;
  localparam int STEPS  = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CROSS  = 4'b0010,
    S_SQRT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  localparam logic [2:0] PH_AB  = 3'd0;
  localparam logic [2:0] PH_CD  = 3'd1;
  localparam logic [2:0] PH_MAG = 3'd2;
  localparam logic [2:0] PH_HH  = 3'd3;
  localparam logic [2:0] PH_HL  = 3'd4;
  localparam logic [2:0] PH_LL  = 3'd5;

  localparam logic [1:0] TERM_FIRST = 2'd0;
  localparam logic [1:0] TERM_TAIL  = 2'd3;

  state_t state;

  logic signed [CB-1:0] fx, fy, fz;
  logic signed [CB-1:0] px, py, pz;
  logic signed [CB-1:0] cx, cy, cz;
  logic                 last_q;
  logic [1:0]           seen;
  logic [SUM_W-1:0]     area_sum;
  logic                 clip;

  logic [1:0]           term;
  logic [2:0]           ph;
  logic signed [PW-1:0] preg;
  logic signed [PW-1:0] prod;
  logic [31:0]          mag_h, mag_l;
  logic                 big;
  logic [ACC_W-1:0]     acc, acc_next, addend;

  logic signed [CB:0]   ux, uy, uz, wx, wy, wz;
  logic signed [MW-1:0] ta, tb, tc, td;
  logic signed [MW-1:0] op_a, op_b;
  logic                 mul_en;

  logic signed [PW:0]   cdiff;
  logic [PW:0]          cmag;

  logic                 sq_start, sq_done;
  logic [pfa_pkg::ROOT_W-1:0] root;

  logic                 big_all;
  logic [SUM_W-1:0]     len;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_new;
  logic                 clip_new;
  logic                 go;
  logic                 emit;

  assign in_ready = (state == S_IDLE);

  assign ux = {px[CB-1], px} - {fx[CB-1], fx};
  assign uy = {py[CB-1], py} - {fy[CB-1], fy};
  assign uz = {pz[CB-1], pz} - {fz[CB-1], fz};
  assign wx = {cx[CB-1], cx} - {fx[CB-1], fx};
  assign wy = {cy[CB-1], cy} - {fy[CB-1], fy};
  assign wz = {cz[CB-1], cz} - {fz[CB-1], fz};

  // Cross term t is ta*tb - tc*td.
  always_comb begin
    unique case (term)
      2'd0: begin
        ta = MW'(uy); tb = MW'(wz); tc = MW'(uz); td = MW'(wy);
      end
      2'd1: begin
        ta = MW'(uz); tb = MW'(wx); tc = MW'(ux); td = MW'(wz);
      end
      2'd2: begin
        ta = MW'(ux); tb = MW'(wy); tc = MW'(uy); td = MW'(wx);
      end
      default: begin
        ta = '0; tb = '0; tc = '0; td = '0;
      end
    endcase
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    unique case (ph)
      PH_AB: begin
        op_a   = ta;
        op_b   = tb;
        mul_en = (state == S_CROSS) && (term != TERM_TAIL);
      end
      PH_CD: begin
        op_a   = tc;
        op_b   = td;
        mul_en = (state == S_CROSS);
      end
      PH_HH: begin
        op_a   = {1'b0, mag_h};
        op_b   = {1'b0, mag_h};
        mul_en = (state == S_CROSS);
      end
      PH_HL: begin
        op_a   = {1'b0, mag_h};
        op_b   = {1'b0, mag_l};
        mul_en = (state == S_CROSS);
      end
      PH_LL: begin
        op_a   = {1'b0, mag_l};
        op_b   = {1'b0, mag_l};
        mul_en = (state == S_CROSS);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  pfa_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (op_a),
    .b    (op_b),
    .prod (prod)
  );

  assign cdiff = {preg[PW-1], preg} - {prod[PW-1], prod};
  assign cmag  = cdiff[PW] ? (PW+1)'(-cdiff) : cdiff;

  // Square of a cross term as h*h << 64 + 2*h*l << 32 + l*l.
  always_comb begin
    unique case (ph)
      PH_AB:   addend = (term != TERM_FIRST) ? ACC_W'(prod[63:0]) : '0;
      PH_HL:   addend = ACC_W'(prod[63:0]) << 64;
      PH_LL:   addend = ACC_W'(prod[63:0]) << 33;
      default: addend = '0;
    endcase
  end

  assign acc_next = acc + addend;
  assign sq_start = (state == S_CROSS) && (term == TERM_TAIL);

  pfa_isqrt #(
    .STEPS (STEPS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc_next[2*STEPS-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  assign big_all  = big | (|acc[ACC_W-1:128]);
  assign len      = big_all ? '1 : root;
  assign sum_add  = {1'b0, area_sum} + {1'b0, len};
  assign sum_new  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign clip_new = clip | big_all | sum_add[SUM_W];
  assign go       = !last_q || !out_valid || out_ready;
  assign emit     = (state == S_FINISH) && go && last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      seen      <= '0;
      area_sum  <= '0;
      clip      <= 1'b0;
      fx <= '0; fy <= '0; fz <= '0;
      px <= '0; py <= '0; pz <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx     <= coord_x;
            cy     <= coord_y;
            cz     <= coord_z;
            last_q <= last_vertex;
            term   <= TERM_FIRST;
            ph     <= PH_AB;
            acc    <= '0;
            big    <= 1'b0;
            state  <= seen[1] ? S_CROSS : S_FINISH;
          end
        end
        S_CROSS: begin
          acc <= acc_next;
          if (ph == PH_CD) begin
            preg <= prod;
          end
          if (ph == PH_MAG) begin
            mag_h <= cmag[63:32];
            mag_l <= cmag[31:0];
            if (|cmag[PW:64]) begin
              big <= 1'b1;
            end
          end
          if (term == TERM_TAIL) begin
            state <= S_SQRT;
          end else if (ph == PH_LL) begin
            ph   <= PH_AB;
            term <= term + 1'b1;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (go) begin
            state <= S_IDLE;
            if (last_q) begin
              // Emit and clear for the next polygon.
              area      <= seen[1] ? sum_new[SUM_W-1:1] : '0;
              saturated <= seen[1] & clip_new;
              seen      <= '0;
              area_sum  <= '0;
              clip      <= 1'b0;
              fx <= '0; fy <= '0; fz <= '0;
              px <= '0; py <= '0; pz <= '0;
            end else begin
              px <= cx; py <= cy; pz <= cz;
              if (seen[1]) begin
                area_sum <= sum_new;
                clip     <= clip_new;
                seen     <= 2'd3;
              end else begin
                if (seen == 2'd0) begin
                  fx <= cx; fy <= cy; fz <= cz;
                end
                seen <= seen + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/polygon_fan_area_test.sv */
// Self-checking testbench for the polygon fan area block.
`timescale 1ns / 100ps

module polygon_fan_area_test;

  localparam int COORD_BITS  = 24;
  localparam int TOTAL_ITEMS = 900;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int LONG_HOLD   = 900;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t ONE  = coord_t'(256);

  typedef enum int {
    STYLE_FULL,
    STYLE_NEAR,
    STYLE_EDGE,
    STYLE_MIXED
  } coord_style_t;

  typedef struct packed {
    logic [pfa_pkg::AREA_W-1:0] area;
    logic                       saturated;
  } area_result_t;

  // Predicts the area of each polygon and checks results in order.
  class polygon_area_board;
    longint                    first_v[3];
    longint                    prev_v[3];
    int unsigned               seen = 0;
    logic [pfa_pkg::SUM_W-1:0] area_sum = '0;
    bit                        sum_clipped = 1'b0;
    area_result_t              areas_due[$];
    int                        errors = 0;

    function void clear_polygon();
      for (int i = 0; i < 3; i++) begin
        first_v[i] = 0;
        prev_v[i]  = 0;
      end
      seen        = 0;
      area_sum    = '0;
      sum_clipped = 1'b0;
    endfunction

    // |a*b - c*d|, exact
    function logic [127:0] cross_mag(longint a, longint b, longint c, longint d);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = 128'(a) * 128'(b);
      q = 128'(c) * 128'(d);
      p = p - q;
      if (p < 0) p = -p;
      return p;
    endfunction

    // Twice the triangle area (first, previous, cur), Q.16, clipped to 64 bits.
    function logic [pfa_pkg::ROOT_W-1:0] doubled_area(input longint cur[3],
                                                      output bit clip);
      longint                     u[3];
      longint                     w[3];
      logic [127:0]               c[3];
      logic [pfa_pkg::ACC_W-1:0]  acc;
      logic [127:0]               sq;
      logic [pfa_pkg::ROOT_W-1:0] root;
      logic [pfa_pkg::ROOT_W-1:0] trial;
      logic [127:0]               trial_sq;
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        u[i] = prev_v[i] - first_v[i];
        w[i] = cur[i] - first_v[i];
      end
      c[0] = cross_mag(u[1], w[2], u[2], w[1]);
      c[1] = cross_mag(u[2], w[0], u[0], w[2]);
      c[2] = cross_mag(u[0], w[1], u[1], w[0]);
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        if (c[i][127:64] != 0) begin
          clip = 1'b1;
        end else begin
          sq  = c[i] * c[i];
          acc = acc + sq;
        end
      end
      if (clip || acc[pfa_pkg::ACC_W-1:128] != 0) begin
        clip = 1'b1;
        return '1;
      end
      root = '0;
      for (int b = pfa_pkg::ROOT_W - 1; b >= 0; b--) begin
        trial    = root | (64'd1 << b);
        trial_sq = {64'd0, trial} * {64'd0, trial};
        if (trial_sq <= acc[127:0]) root = trial;
      end
      return root;
    endfunction

    function void note_vertex(coord_t x, coord_t y, coord_t z, logic last);
      longint                     v[3];
      logic [pfa_pkg::ROOT_W-1:0] len;
      logic [pfa_pkg::SUM_W:0]    total;
      bit                         clip;
      area_result_t               due;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      if (seen == 0) begin
        first_v = v;
        prev_v  = v;
        seen    = 1;
      end else if (seen == 1) begin
        prev_v = v;
        seen   = 2;
      end else begin
        len = doubled_area(v, clip);
        if (clip) sum_clipped = 1'b1;
        total = {1'b0, area_sum} + {1'b0, len};
        if (total[pfa_pkg::SUM_W]) begin
          area_sum    = '1;
          sum_clipped = 1'b1;
        end else begin
          area_sum = total[pfa_pkg::SUM_W-1:0];
        end
        prev_v = v;
        seen   = 3;
      end
      if (last) begin
        if (seen >= 3) begin
          due.area      = area_sum[pfa_pkg::SUM_W-1:1];
          due.saturated = sum_clipped;
        end else begin
          due = '0;
        end
        areas_due = {areas_due, due};
        clear_polygon();
      end
    endfunction

    function void check_result(logic [pfa_pkg::AREA_W-1:0] got_area, logic got_sat);
      area_result_t due;
      if (areas_due.size() == 0) begin
        $error("result with no polygon pending: area %0d saturated %0b", got_area, got_sat);
        errors++;
        return;
      end
      due = areas_due.pop_front();
      if (got_area !== due.area) begin
        $error("area: expected %0d, got %0d", due.area, got_area);
        errors++;
      end
      if (got_sat !== due.saturated) begin
        $error("saturated: expected %0b, got %0b", due.saturated, got_sat);
        errors++;
      end
    endfunction

    function int pending();
      return areas_due.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  coord_t                     coord_x = '0;
  coord_t                     coord_y = '0;
  coord_t                     coord_z = '0;
  logic                       last_vertex = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [pfa_pkg::AREA_W-1:0] area;
  logic                       saturated;

  polygon_area_board board;
  int                sent = 0;
  bit                steady = 1'b0;
  int                hold_request = 0;

  polygon_fan_area #(
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .area(area),
    .saturated(saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic coord_t pick_coord(coord_style_t style);
    coord_style_t s;
    s = style;
    if (s == STYLE_MIXED) s = coord_style_t'($urandom_range(0, 2));
    case (s)
      STYLE_NEAR: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      STYLE_EDGE: begin
        case ($urandom_range(0, 3))
          0: return CMIN;
          1: return CMAX;
          2: return '0;
          default: return coord_t'($urandom);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    last_vertex <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_vertex(x, y, z, last);
    sent++;
  endtask

  task automatic send_polygon(input int verts, input coord_style_t style);
    for (int i = 0; i < verts; i++)
      send_vertex(pick_coord(style), pick_coord(style), pick_coord(style), i == verts - 1);
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && out_ready) board.check_result(area, saturated);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
        if (idle >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int verts;
    int roll;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // too few vertices: area zero
    send_vertex('0, '0, '0, 1'b1);
    send_vertex(CMAX, CMAX, CMAX, 1'b0);
    send_vertex(CMIN, CMIN, CMIN, 1'b1);
    // unit right triangle
    send_vertex('0, '0, '0, 1'b0);
    send_vertex(ONE, '0, '0, 1'b0);
    send_vertex('0, ONE, '0, 1'b1);
    // largest legs along the axes
    send_vertex(CMIN, CMIN, CMIN, 1'b0);
    send_vertex(CMAX, CMIN, CMIN, 1'b0);
    send_vertex(CMIN, CMAX, CMIN, 1'b1);
    // skewed triangle spanning the whole cube
    send_vertex(CMIN, CMIN, CMIN, 1'b0);
    send_vertex(CMAX, CMAX, CMIN, 1'b0);
    send_vertex(CMIN, CMAX, CMAX, 1'b1);
    // duplicate vertices: zero length
    send_vertex(coord_t'(5), coord_t'(-5), coord_t'(5), 1'b0);
    send_vertex(coord_t'(5), coord_t'(-5), coord_t'(5), 1'b0);
    send_vertex(coord_t'(5), coord_t'(-5), coord_t'(5), 1'b1);
    // pentagon with a repeated vertex and mixed extremes
    send_vertex('0, '0, CMAX, 1'b0);
    send_vertex(CMAX, '0, CMAX, 1'b0);
    send_vertex(CMAX, CMAX, '0, 1'b0);
    send_vertex(CMAX, CMAX, '0, 1'b0);
    send_vertex(CMIN, CMAX, CMIN, 1'b1);

    while (sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      roll = $urandom_range(0, 99);
      if (roll < 10) verts = $urandom_range(1, 2);
      else if (roll < 80) verts = $urandom_range(3, 6);
      else verts = $urandom_range(7, 12);
      send_polygon(verts, coord_style_t'($urandom_range(0, 3)));

      // Hold off the receiver and keep sending so the block backs up,
      // then let everything drain before going on.
      if (sent >= 300 && hold_request == 0 && board.errors >= 0 && sent < 320) begin
        hold_request = LONG_HOLD;
        steady = 1'b1;
        for (int i = 0; i < 4; i++) send_polygon(3, STYLE_FULL);
        steady = 1'b0;
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pfa_pkg.sv
sv/pfa_mul.sv
sv/pfa_isqrt.sv
sv/polygon_fan_area.sv
tb/sv/polygon_fan_area_test.sv
